FILE: src/sat_pkg.sv
`timescale 1ns / 1ps

package sat_pkg;

	localparam int VERT_W     = 32;
	localparam int AXIS_W     = 16;
	localparam int ROT_W      = 16;
	localparam int REL_W      = 32;
	localparam int PROJ_W     = 48;
	localparam int DEPTH_W    = 50;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_00 = 3'd0,
		REG_ROT_01 = 3'd1,
		REG_ROT_10 = 3'd2,
		REG_ROT_11 = 3'd3,
		REG_REL_X  = 3'd4,
		REG_REL_Y  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [ROT_W-1:0] rot_00;
		logic signed [ROT_W-1:0] rot_01;
		logic signed [ROT_W-1:0] rot_10;
		logic signed [ROT_W-1:0] rot_11;
		logic signed [REL_W-1:0] rel_x;
		logic signed [REL_W-1:0] rel_y;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		rot_00: 16'sd16384,
		rot_01: 16'sd0,
		rot_10: 16'sd0,
		rot_11: 16'sd16384,
		rel_x:  32'sd0,
		rel_y:  32'sd0
	};

	// One classified vertex as it waits between the front and back ends.
	typedef struct packed {
		logic signed [VERT_W-1:0] vert_x;
		logic signed [VERT_W-1:0] vert_y;
		logic                     from_b;
		logic                     last;
		logic signed [AXIS_W-1:0] proj_x;
		logic signed [AXIS_W-1:0] proj_y;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
	} sat_item_t;

endpackage

FILE: src/sat_ifs.sv
`timescale 1ns / 1ps

interface sat_vert_if import sat_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [VERT_W-1:0] vert_x;
	logic signed [VERT_W-1:0] vert_y;
	logic                     from_b;
	logic                     last;
	logic signed [AXIS_W-1:0] axis_x;
	logic signed [AXIS_W-1:0] axis_y;

	modport source (output valid, output vert_x, output vert_y, output from_b,
		output last, output axis_x, output axis_y, input ready);
	modport sink (input valid, input vert_x, input vert_y, input from_b,
		input last, input axis_x, input axis_y, output ready);
endinterface

interface sat_result_if import sat_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      overlap;
	logic signed [DEPTH_W-1:0] depth;
	logic                      empty_poly;

	modport source (output valid, output overlap, output depth, output empty_poly,
		input ready);
	modport sink (input valid, input overlap, input depth, input empty_poly,
		output ready);
endinterface

FILE: src/sat_front.sv
`timescale 1ns / 1ps

module sat_front import sat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	sat_vert_if.sink   vert,
	output logic       push_valid,
	input  logic       push_ready,
	output sat_item_t  push_data
);

	localparam int PROD_W = 2 * ROT_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int FRAC   = 14;
	localparam int SHR_W  = SUM_W - FRAC;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_00_s1, prod_01_s1, prod_10_s1, prod_11_s1;
	logic signed [VERT_W-1:0] vert_x_s1, vert_y_s1;
	logic                     from_b_s1, last_s1;
	logic signed [AXIS_W-1:0] axis_x_s1, axis_y_s1;

	logic                     accept;
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	logic signed [AXIS_W-1:0] rot_x, rot_y;

	function automatic logic signed [AXIS_W-1:0] clamp_axis(input logic signed [SHR_W-1:0] v);
		logic signed [SHR_W-1:0] hi;
		logic signed [SHR_W-1:0] lo;
		hi = SHR_W'(32767);
		lo = -SHR_W'(32768);
		if (v > hi) begin
			return AXIS_W'(hi);
		end else if (v < lo) begin
			return AXIS_W'(lo);
		end
		return v[AXIS_W-1:0];
	endfunction

	assign accept     = vert.valid && vert.ready;
	assign vert.ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_00_s1 <= PROD_W'(cfg.rot_00) * PROD_W'(vert.axis_x);
			prod_01_s1 <= PROD_W'(cfg.rot_01) * PROD_W'(vert.axis_y);
			prod_10_s1 <= PROD_W'(cfg.rot_10) * PROD_W'(vert.axis_x);
			prod_11_s1 <= PROD_W'(cfg.rot_11) * PROD_W'(vert.axis_y);
			vert_x_s1  <= vert.vert_x;
			vert_y_s1  <= vert.vert_y;
			from_b_s1  <= vert.from_b;
			last_s1    <= vert.last;
			axis_x_s1  <= vert.axis_x;
			axis_y_s1  <= vert.axis_y;
		end
	end

	// Dropping the low fraction bits of a two's complement sum rounds toward minus infinity.
	assign sum_x = SUM_W'(prod_00_s1) + SUM_W'(prod_01_s1);
	assign sum_y = SUM_W'(prod_10_s1) + SUM_W'(prod_11_s1);
	assign rot_x = clamp_axis(sum_x[SUM_W-1:FRAC]);
	assign rot_y = clamp_axis(sum_y[SUM_W-1:FRAC]);

	assign push_valid       = valid_s1;
	assign push_data.vert_x = vert_x_s1;
	assign push_data.vert_y = vert_y_s1;
	assign push_data.from_b = from_b_s1;
	assign push_data.last   = last_s1;
	assign push_data.proj_x = from_b_s1 ? axis_x_s1 : rot_x;
	assign push_data.proj_y = from_b_s1 ? axis_y_s1 : rot_y;
	assign push_data.axis_x = axis_x_s1;
	assign push_data.axis_y = axis_y_s1;

endmodule

FILE: src/sat_fifo.sv
`timescale 1ns / 1ps

module sat_fifo import sat_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  sat_item_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output sat_item_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sat_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while the queue is empty");

endmodule

FILE: src/sat_back.sv
`timescale 1ns / 1ps

module sat_back import sat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  sat_item_t   pop_data,
	sat_result_if.source result
);

	localparam int SUM_W = PROJ_W + 1;
	localparam logic signed [SUM_W-1:0] P_MAX = SUM_W'(48'sh7FFF_FFFF_FFFF);
	localparam logic signed [SUM_W-1:0] P_MIN = -P_MAX - SUM_W'(1);

	logic en;

	logic                     valid_s2, from_b_s2, last_s2;
	logic signed [PROJ_W-1:0] pa_s2, pb_s2, ha_s2, hb_s2;

	logic                     valid_s3, from_b_s3, last_s3;
	logic signed [PROJ_W-1:0] p_s3, h_s3;

	logic signed [PROJ_W-1:0] a_min_q, a_max_q, b_min_q, b_max_q;
	logic                     a_seen_q, b_seen_q;
	logic signed [PROJ_W-1:0] a_min_n, a_max_n, b_min_n, b_max_n;
	logic                     a_seen_n, b_seen_n;

	logic                     valid_s4, empty_s4;
	logic signed [PROJ_W-1:0] a_min_s4, a_max_s4, b_min_s4, b_max_s4, h_s4;

	logic                      valid_s5, empty_s5;
	logic signed [DEPTH_W-1:0] d0_s5, d1_s5;

	logic                      out_valid_q, overlap_q, empty_q;
	logic signed [DEPTH_W-1:0] depth_q;
	logic                      hit;

	function automatic logic signed [PROJ_W-1:0] clamp_proj(input logic signed [SUM_W-1:0] v);
		if (v > P_MAX) begin
			return PROJ_W'(P_MAX);
		end else if (v < P_MIN) begin
			return PROJ_W'(P_MIN);
		end
		return v[PROJ_W-1:0];
	endfunction

	// The whole back end moves as one; it halts only while a result waits at the output.
	assign en        = !out_valid_q || result.ready;
	assign pop_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
			a_seen_q    <= 1'b0;
			b_seen_q    <= 1'b0;
		end else if (en) begin
			valid_s2    <= pop_valid;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3 && last_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
			if (valid_s3 && last_s3) begin
				a_seen_q <= 1'b0;
				b_seen_q <= 1'b0;
			end else begin
				a_seen_q <= a_seen_n;
				b_seen_q <= b_seen_n;
			end
		end
	end

	always_comb begin
		a_min_n  = a_min_q;
		a_max_n  = a_max_q;
		b_min_n  = b_min_q;
		b_max_n  = b_max_q;
		a_seen_n = a_seen_q;
		b_seen_n = b_seen_q;
		if (valid_s3) begin
			if (from_b_s3) begin
				b_seen_n = 1'b1;
				if (!b_seen_q) begin
					b_min_n = p_s3;
					b_max_n = p_s3;
				end else begin
					if (p_s3 < b_min_q) begin
						b_min_n = p_s3;
					end
					if (p_s3 > b_max_q) begin
						b_max_n = p_s3;
					end
				end
			end else begin
				a_seen_n = 1'b1;
				if (!a_seen_q) begin
					a_min_n = p_s3;
					a_max_n = p_s3;
				end else begin
					if (p_s3 < a_min_q) begin
						a_min_n = p_s3;
					end
					if (p_s3 > a_max_q) begin
						a_max_n = p_s3;
					end
				end
			end
		end
	end

	assign hit = !empty_s5 && (d0_s5 <= DEPTH_W'(0)) && (d1_s5 <= DEPTH_W'(0));

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s2     <= PROJ_W'(pop_data.vert_x) * PROJ_W'(pop_data.proj_x);
			pb_s2     <= PROJ_W'(pop_data.vert_y) * PROJ_W'(pop_data.proj_y);
			ha_s2     <= PROJ_W'(cfg.rel_x) * PROJ_W'(pop_data.axis_x);
			hb_s2     <= PROJ_W'(cfg.rel_y) * PROJ_W'(pop_data.axis_y);
			from_b_s2 <= pop_data.from_b;
			last_s2   <= pop_data.last;

			p_s3      <= clamp_proj(SUM_W'(pa_s2) + SUM_W'(pb_s2));
			h_s3      <= clamp_proj(SUM_W'(ha_s2) + SUM_W'(hb_s2));
			from_b_s3 <= from_b_s2;
			last_s3   <= last_s2;

			a_min_q <= a_min_n;
			a_max_q <= a_max_n;
			b_min_q <= b_min_n;
			b_max_q <= b_max_n;

			a_min_s4 <= a_min_n;
			a_max_s4 <= a_max_n;
			b_min_s4 <= b_min_n;
			b_max_s4 <= b_max_n;
			h_s4     <= h_s3;
			empty_s4 <= !a_seen_n || !b_seen_n;

			d0_s5    <= DEPTH_W'(a_min_s4) + DEPTH_W'(h_s4) - DEPTH_W'(b_max_s4);
			d1_s5    <= DEPTH_W'(b_min_s4) - DEPTH_W'(a_max_s4) - DEPTH_W'(h_s4);
			empty_s5 <= empty_s4;

			overlap_q <= hit;
			empty_q   <= empty_s5;
			if (hit) begin
				depth_q <= (d0_s5 > d1_s5) ? d0_s5 : d1_s5;
			end else begin
				depth_q <= '0;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.overlap    = overlap_q;
	assign result.depth      = depth_q;
	assign result.empty_poly = empty_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		a_seen_q |-> (a_min_q <= a_max_q))
		else $error("polygon A interval is inverted");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (!overlap_q && depth_q == '0))
		else $error("empty polygon result reports overlap or depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && overlap_q) |-> (depth_q <= DEPTH_W'(0)))
		else $error("overlap reported with a positive depth");

endmodule

FILE: src/sat_axis_interval_overlap_core.sv
`timescale 1ns / 1ps

// Channel   Role     Transaction
// vert      sink     one vertex: vert_x, vert_y, from_b, last, axis_x, axis_y
// result    source   one test result: overlap, depth, empty_poly
// cfg_*     write    register index and data, taken on every cycle with cfg_we high
//
// One vertex is taken per cycle unless a stalled result backs up the queue; the front end, the queue
// and the back end each pass one transaction a cycle, and the min/max update keeps pace with them.
// After its last vertex is accepted, a result passes the front stage, the queue, s2 to s5 and the output register.
// arst_n clears all control state and loads the register reset values.
// A stalled result holds the back end; the queue then absorbs up to FIFO_DEPTH
// vertices plus one in the front stage before vert.ready drops.

module sat_axis_interval_overlap_core import sat_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sat_vert_if.sink              vert,
	sat_result_if.source          result
);

	cfg_t      cfg_q;
	logic      push_valid, push_ready, pop_valid, pop_ready;
	sat_item_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_00: begin
					cfg_q.rot_00 <= cfg_data[ROT_W-1:0];
				end
				REG_ROT_01: begin
					cfg_q.rot_01 <= cfg_data[ROT_W-1:0];
				end
				REG_ROT_10: begin
					cfg_q.rot_10 <= cfg_data[ROT_W-1:0];
				end
				REG_ROT_11: begin
					cfg_q.rot_11 <= cfg_data[ROT_W-1:0];
				end
				REG_REL_X: begin
					cfg_q.rel_x <= cfg_data[REL_W-1:0];
				end
				REG_REL_Y: begin
					cfg_q.rel_y <= cfg_data[REL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.vert       (vert),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sat_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

FILE: dv/tb_sat_axis_interval_overlap_core.sv
`timescale 1ns / 1ps

module tb_sat_axis_interval_overlap_core;
	import sat_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam longint PROJ_MAX = (longint'(1) <<< (PROJ_W - 1)) - 1;
	localparam longint PROJ_MIN = -(longint'(1) <<< (PROJ_W - 1));
	localparam int     AXIS_MAX = 32767;
	localparam int     AXIS_MIN = -32768;
	localparam int     ONE      = 65536;     // 1.0 in Q16.16
	localparam int     UNIT_AX  = 16384;     // 1.0 in Q2.14
	localparam int     SETTLE   = 20;

	typedef struct {
		logic signed [VERT_W-1:0] vx;
		logic signed [VERT_W-1:0] vy;
		logic                     from_b;
		logic                     last;
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
	} vertex_t;

	typedef struct {
		logic                      overlap;
		logic signed [DEPTH_W-1:0] depth;
		logic                      empty_poly;
	} overlap_res_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sat_vert_if   vert_if ();
	sat_result_if res_if ();

	sat_axis_interval_overlap_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vert      (vert_if),
		.result    (res_if)
	);

	// Shadow of the block: register copy and running intervals.
	cfg_t   shadow_cfg = CFG_RESET;
	longint a_lo = 0, a_hi = 0, b_lo = 0, b_hi = 0;
	bit     a_any = 0, b_any = 0;

	vertex_t      vertex_backlog[$];
	overlap_res_t overlap_expected[$];

	int mismatches   = 0;
	int results_seen = 0;
	bit steady_send  = 0;
	bit steady_ready = 0;

	int      gap_left   = 0;
	vertex_t cur;
	int      stall_left = 0;
	int      hold_left  = 0;
	bit      hold_done  = 0;
	logic    rdy_next;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint project(longint x, longint y, longint ax, longint ay);
		return clamp(x * ax + y * ay, PROJ_MIN, PROJ_MAX);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int pick_coord(int mode);
		int r;
		if (mode < 6)
			return int'($urandom_range(0, 2097152)) - 1048576;
		if (mode < 9)
			return int'($urandom());
		r = $urandom_range(0, 5);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 0;
			3: return -1;
			4: return ONE;
			default: return -ONE;
		endcase
	endfunction

	function automatic int pick_axis();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return int'($urandom_range(0, 32768)) - UNIT_AX;
		if (r < 80)
			return int'($urandom());
		r = $urandom_range(0, 4);
		case (r)
			0: return AXIS_MIN;
			1: return AXIS_MAX;
			2: return 0;
			3: return UNIT_AX;
			default: return -UNIT_AX;
		endcase
	endfunction

	// Folds one accepted vertex into the shadow intervals; a last vertex yields a result.
	task automatic absorb_vertex(vertex_t v);
		longint       ax, ay, rx, ry, p, h, d0, d1;
		overlap_res_t r;
		ax = longint'(v.ax);
		ay = longint'(v.ay);
		if (v.from_b) begin
			p = project(longint'(v.vx), longint'(v.vy), ax, ay);
			if (!b_any) begin
				b_lo = p;
				b_hi = p;
				b_any = 1'b1;
			end else begin
				if (p < b_lo) b_lo = p;
				if (p > b_hi) b_hi = p;
			end
		end else begin
			rx = clamp((longint'(shadow_cfg.rot_00) * ax + longint'(shadow_cfg.rot_01) * ay)
				>>> 14, longint'(AXIS_MIN), longint'(AXIS_MAX));
			ry = clamp((longint'(shadow_cfg.rot_10) * ax + longint'(shadow_cfg.rot_11) * ay)
				>>> 14, longint'(AXIS_MIN), longint'(AXIS_MAX));
			p = project(longint'(v.vx), longint'(v.vy), rx, ry);
			if (!a_any) begin
				a_lo = p;
				a_hi = p;
				a_any = 1'b1;
			end else begin
				if (p < a_lo) a_lo = p;
				if (p > a_hi) a_hi = p;
			end
		end
		if (!v.last)
			return;
		if (!a_any || !b_any) begin
			r.overlap = 1'b0;
			r.depth = '0;
			r.empty_poly = 1'b1;
		end else begin
			h = project(longint'(shadow_cfg.rel_x), longint'(shadow_cfg.rel_y), ax, ay);
			d0 = a_lo + h - b_hi;
			d1 = b_lo - (a_hi + h);
			// A gap of exactly zero still counts as touching, hence overlapping.
			if (d0 > 0 || d1 > 0) begin
				r.overlap = 1'b0;
				r.depth = '0;
			end else begin
				r.overlap = 1'b1;
				r.depth = DEPTH_W'((d0 > d1) ? d0 : d1);
			end
			r.empty_poly = 1'b0;
		end
		overlap_expected.push_back(r);
		a_any = 1'b0;
		b_any = 1'b0;
	endtask

	task automatic report(string what, longint want, longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		mismatches++;
	endtask

	task automatic push_vtx(bit from_b, bit last, int vx, int vy, int ax, int ay);
		vertex_t v;
		v.vx = vx;
		v.vy = vy;
		v.from_b = from_b;
		v.last = last;
		v.ax = AXIS_W'(ax);
		v.ay = AXIS_W'(ay);
		vertex_backlog.push_back(v);
	endtask

	// One axis test: vertices of one polygon or both in random order, the final one marked last.
	task automatic gen_test();
		int  kind, na, nb, n, cm;
		int  ax, ay;
		bit  noise, b;
		kind = $urandom_range(0, 99);
		noise = 0;
		if (kind < 80) begin
			na = $urandom_range(1, 5);
			nb = $urandom_range(1, 5);
		end else if (kind < 88) begin
			na = $urandom_range(0, 3);
			nb = (na == 0) ? $urandom_range(1, 3) : 0;
		end else if (kind < 95) begin
			na = $urandom_range(0, 3);
			nb = $urandom_range(1, 3);
			noise = 1;
		end else begin
			na = $urandom_range(8, 16);
			nb = $urandom_range(8, 16);
		end
		cm = $urandom_range(0, 9);
		ax = pick_axis();
		ay = pick_axis();
		n = na + nb;
		for (int i = 0; i < n; i++) begin
			if (na == 0)
				b = 1;
			else if (nb == 0)
				b = 0;
			else
				b = ($urandom_range(0, na + nb - 1) >= na);
			if (b)
				nb--;
			else
				na--;
			if (noise) begin
				ax = pick_axis();
				ay = pick_axis();
				cm = $urandom_range(0, 9);
			end
			push_vtx(b, i == n - 1, pick_coord(cm), pick_coord(cm), ax, ay);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ROT_00: shadow_cfg.rot_00 = data[ROT_W-1:0];
			REG_ROT_01: shadow_cfg.rot_01 = data[ROT_W-1:0];
			REG_ROT_10: shadow_cfg.rot_10 = data[ROT_W-1:0];
			REG_ROT_11: shadow_cfg.rot_11 = data[ROT_W-1:0];
			REG_REL_X:  shadow_cfg.rel_x = data[REL_W-1:0];
			REG_REL_Y:  shadow_cfg.rel_y = data[REL_W-1:0];
			default: ;
		endcase
	endtask

	// Upper data bits of the 16-bit registers are filled with noise; the block ignores them.
	task automatic set_cfg(int r00, int r01, int r10, int r11, int rx, int ry);
		write_reg(REG_ROT_00, {16'($urandom()), 16'(r00)});
		write_reg(REG_ROT_01, {16'($urandom()), 16'(r01)});
		write_reg(REG_ROT_10, {16'($urandom()), 16'(r10)});
		write_reg(REG_ROT_11, {16'($urandom()), 16'(r11)});
		write_reg(REG_REL_X, rx);
		write_reg(REG_REL_Y, ry);
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_random_cfg();
		int rot[4];
		int rx, ry;
		for (int i = 0; i < 4; i++)
			rot[i] = $urandom_range(0, 1) ? int'($urandom_range(0, 32768)) - UNIT_AX
				: int'($urandom());
		if ($urandom_range(0, 9) < 7) begin
			rx = pick_coord(0);
			ry = pick_coord(0);
		end else begin
			rx = $urandom();
			ry = $urandom();
		end
		set_cfg(rot[0], rot[1], rot[2], rot[3], rx, ry);
	endtask

	// Idle means every vertex is taken and every predicted result has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (vertex_backlog.size() != 0 || vert_if.valid || overlap_expected.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_random(int n_items);
		while (vertex_backlog.size() < n_items)
			gen_test();
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Vertex driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			vert_if.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (vert_if.valid && vert_if.ready)
				absorb_vertex(cur);
			if (!vert_if.valid || vert_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					vert_if.valid <= 1'b0;
				end else if (vertex_backlog.size() != 0) begin
					cur = vertex_backlog.pop_front();
					vert_if.valid <= 1'b1;
					vert_if.vert_x <= cur.vx;
					vert_if.vert_y <= cur.vy;
					vert_if.from_b <= cur.from_b;
					vert_if.last <= cur.last;
					vert_if.axis_x <= cur.ax;
					vert_if.axis_y <= cur.ay;
					gap_left = steady_send ? 0 : pick_gap();
				end else begin
					vert_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				if (overlap_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual overlap=%0b depth=%0d empty=%0b",
						$time, res_if.overlap, res_if.depth, res_if.empty_poly);
					mismatches++;
				end else begin
					overlap_res_t want;
					want = overlap_expected.pop_front();
					if (res_if.overlap !== want.overlap)
						report("overlap", longint'(want.overlap), longint'(res_if.overlap));
					if (res_if.depth !== want.depth)
						report("depth", longint'(want.depth), longint'(res_if.depth));
					if (res_if.empty_poly !== want.empty_poly)
						report("empty_poly", longint'(want.empty_poly),
							longint'(res_if.empty_poly));
				end
			end
			// One long hold-off lets the internal queue fill and stall the vertex input.
			if (hold_left > 0) begin
				hold_left--;
				rdy_next = 1'b0;
			end else if (!hold_done && results_seen >= 40) begin
				hold_done = 1;
				hold_left = 80;
				rdy_next = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy_next = 1'b0;
			end else begin
				rdy_next = 1'b1;
				if (!steady_ready && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
			res_if.ready <= rdy_next;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vert_if.valid = 1'b0;
		vert_if.vert_x = '0;
		vert_if.vert_y = '0;
		vert_if.from_b = 1'b0;
		vert_if.last = 1'b0;
		vert_if.axis_x = '0;
		vert_if.axis_y = '0;
		res_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases under the reset registers: identity rotation, zero offset.
		push_vtx(1, 1, 0, 0, UNIT_AX, 0);                 // polygon A never seen
		push_vtx(0, 1, ONE, 0, UNIT_AX, 0);               // polygon B never seen
		push_vtx(0, 0, 0, 0, UNIT_AX, 0);                 // single points, both at origin
		push_vtx(1, 1, 0, 0, UNIT_AX, 0);
		push_vtx(0, 0, 0, 0, UNIT_AX, 0);                 // A touches B from the left
		push_vtx(0, 0, ONE, 0, UNIT_AX, 0);
		push_vtx(1, 0, ONE, 0, UNIT_AX, 0);
		push_vtx(1, 1, 2 * ONE, 0, UNIT_AX, 0);
		push_vtx(0, 0, 2 * ONE, 0, UNIT_AX, 0);           // A touches B from the right
		push_vtx(0, 0, 3 * ONE, 0, UNIT_AX, 0);
		push_vtx(1, 0, ONE, 0, UNIT_AX, 0);
		push_vtx(1, 1, 2 * ONE, 0, UNIT_AX, 0);
		push_vtx(0, 0, 0, 0, UNIT_AX, 0);                 // clear separation
		push_vtx(1, 1, 3 * ONE, 0, UNIT_AX, 0);
		push_vtx(0, 0, -ONE, 0, UNIT_AX, 0);              // partial overlap
		push_vtx(0, 0, ONE, 0, UNIT_AX, 0);
		push_vtx(1, 0, 0, 0, UNIT_AX, 0);
		push_vtx(1, 1, 2 * ONE, 0, UNIT_AX, 0);
		// Projections near both ends of the 48-bit range; only the top end saturates.
		push_vtx(0, 0, 32'h8000_0000, 32'h8000_0000, AXIS_MIN, AXIS_MIN);
		push_vtx(1, 0, 32'h7fff_ffff, 32'h7fff_ffff, AXIS_MIN, AXIS_MIN);
		push_vtx(1, 1, 32'h8000_0000, 32'h8000_0000, AXIS_MIN, AXIS_MIN);
		push_vtx(0, 0, 32'h7fff_ffff, 32'h8000_0000, AXIS_MAX, AXIS_MIN);
		push_vtx(0, 0, 32'h8000_0000, 32'h7fff_ffff, AXIS_MAX, AXIS_MAX);
		push_vtx(1, 0, 32'h7fff_ffff, 32'h7fff_ffff, AXIS_MAX, AXIS_MAX);
		push_vtx(1, 1, 0, 3 * ONE, 0, UNIT_AX);
		drain();

		set_random_cfg();
		run_random(110);

		steady_send = 1;
		steady_ready = 1;
		set_cfg(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, 32'h7fff_ffff, 32'h7fff_ffff);
		run_random(110);

		steady_send = 0;
		steady_ready = 0;
		set_cfg(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'h8000_0000, 32'h8000_0000);
		run_random(110);

		for (int ph = 0; ph < 5; ph++) begin
			steady_send = ($urandom_range(0, 3) == 0);
			steady_ready = ($urandom_range(0, 3) == 0);
			set_random_cfg();
			run_random(110);
		end

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
